// ===== src/cfvs_pkg.sv =====
// Shared types, reset values, register indexes and saturating arithmetic
// for the coupled-field Verlet stencil step. No dependencies.
package cfvs_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 22;
  localparam int MAX_W             = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int PIDX_W            = 16;

  localparam logic [PIDX_W-1:0] MIN_POINTS = 16'd3;

  localparam logic signed [63:0] RST_MU    = -64'sd83886080;
  localparam logic [63:0]        RST_KAPPA = 64'd83886080;
  localparam logic [63:0]        RST_MASS  = 64'd4194304;
  localparam logic [63:0]        RST_INVDX = 64'd1677721600;
  localparam logic [63:0]        RST_DT    = 64'd167772;
  localparam logic [PIDX_W-1:0]  RST_GRID  = 16'd4000;

  localparam logic [CFG_IDX_W-1:0] CFG_MU    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVDX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID  = 3'd5;

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_KICK   = 17'h00002,
    ST_DRIFT  = 17'h00004,
    ST_LAP    = 17'h00008,
    ST_MASS   = 17'h00010,
    ST_DPROD  = 17'h00020,
    ST_FWAIT  = 17'h00040,
    ST_NUM    = 17'h00080,
    ST_DIV    = 17'h00100,
    ST_KICK2  = 17'h00200,
    ST_DAMPF  = 17'h00400,
    ST_DAMPV  = 17'h00800,
    ST_EMIT1  = 17'h01000,
    ST_DAMPF2 = 17'h02000,
    ST_DAMPV2 = 17'h04000,
    ST_EMIT2  = 17'h08000,
    ST_FINISH = 17'h10000
  } cfvs_state_t;

  typedef struct packed {
    cfvs_state_t st;
    logic        ph;
    logic        bound;
    logic        load;
    logic        shift;
  } cfvs_ctl_t;

  function automatic logic signed [MAX_W-1:0] sat_clamp(input logic signed [MAX_W:0] s,
                                                        input int unsigned w);
    logic signed [MAX_W:0] hi;
    logic signed [MAX_W:0] lo;
    hi = ((MAX_W+1)'(1) <<< (w - 1)) - (MAX_W+1)'(1);
    lo = -hi - (MAX_W+1)'(1);
    if (s > hi) sat_clamp = hi[MAX_W-1:0];
    else if (s < lo) sat_clamp = lo[MAX_W-1:0];
    else sat_clamp = s[MAX_W-1:0];
  endfunction

  function automatic logic signed [MAX_W-1:0] sat_add(input logic signed [MAX_W-1:0] a,
                                                      input logic signed [MAX_W-1:0] b,
                                                      input int unsigned w);
    sat_add = sat_clamp((MAX_W+1)'(a) + (MAX_W+1)'(b), w);
  endfunction

  function automatic logic signed [MAX_W-1:0] sat_sub(input logic signed [MAX_W-1:0] a,
                                                      input logic signed [MAX_W-1:0] b,
                                                      input int unsigned w);
    sat_sub = sat_clamp((MAX_W+1)'(a) - (MAX_W+1)'(b), w);
  endfunction

endpackage

// ===== src/cfvs_if.sv =====
// Handshake channels of the stencil step: grid point in, result out, config write.
// Depends on cfvs_pkg.
interface cfvs_in_if #(parameter int W = 32, parameter int F = 22);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] field_one;
  logic signed [W-1:0] field_two;
  logic signed [W-1:0] field_three;
  logic signed [W-1:0] speed_one;
  logic signed [W-1:0] speed_two;
  logic signed [W-1:0] speed_three;
  logic signed [W-1:0] accel_one;
  logic signed [W-1:0] accel_two;
  logic signed [W-1:0] accel_three;
  logic [F:0]          damping;
  modport source (output valid, field_one, field_two, field_three, speed_one, speed_two,
                  speed_three, accel_one, accel_two, accel_three, damping, input ready);
  modport sink (input valid, field_one, field_two, field_three, speed_one, speed_two,
                speed_three, accel_one, accel_two, accel_three, damping, output ready);
endinterface

interface cfvs_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_field_one;
  logic signed [W-1:0] new_field_two;
  logic signed [W-1:0] new_field_three;
  logic signed [W-1:0] new_speed_one;
  logic signed [W-1:0] new_speed_two;
  logic signed [W-1:0] new_speed_three;
  logic signed [W-1:0] new_accel_one;
  logic signed [W-1:0] new_accel_two;
  logic signed [W-1:0] new_accel_three;
  logic                sweep_end;
  modport source (output valid, new_field_one, new_field_two, new_field_three, new_speed_one,
                  new_speed_two, new_speed_three, new_accel_one, new_accel_two,
                  new_accel_three, sweep_end, input ready);
  modport sink (input valid, new_field_one, new_field_two, new_field_three, new_speed_one,
                new_speed_two, new_speed_three, new_accel_one, new_accel_two,
                new_accel_three, sweep_end, output ready);
endinterface

interface cfvs_cfg_if #(parameter int W = 32);
  logic                             valid;
  logic                             ready;
  logic [cfvs_pkg::CFG_IDX_W-1:0]   index;
  logic [W-1:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cfvs_fmul.sv =====
// Two-stage fixed-point multiplier: registered magnitude product, then
// round half away from zero, shift by F or F+1 and saturate. No dependencies.
module cfvs_fmul #(
  parameter int W = 32,
  parameter int F = 22
) (
  input  logic                clk,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic                half_i,
  output logic signed [W-1:0] res_o
);
  localparam int PW = 2 * W + 1;
  localparam logic [PW-1:0] HALF_F   = PW'(1) << (F - 1);
  localparam logic [PW-1:0] HALF_F1  = PW'(1) << F;
  localparam logic [PW-1:0] LIM_NEG  = PW'(1) << (W - 1);
  localparam logic [PW-1:0] LIM_POS  = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [2*W-1:0] prod_r;
  logic           neg_r;
  logic           half_r;
  logic [PW-1:0]  rnd;
  logic [PW-1:0]  sh;

  assign ma = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mb = b_i[W-1] ? W'(-b_i) : W'(b_i);

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    neg_r  <= a_i[W-1] ^ b_i[W-1];
    half_r <= half_i;
  end

  assign rnd = PW'(prod_r) + (half_r ? HALF_F1 : HALF_F);
  assign sh  = half_r ? (rnd >> (F + 1)) : (rnd >> F);

  always_comb begin
    if (neg_r) res_o = (sh > LIM_NEG) ? VMIN : W'(PW'(0) - sh);
    else res_o = (sh > LIM_POS) ? VMAX : W'(sh);
  end

endmodule

// ===== src/cfvs_lane.sv =====
// One field lane: kicks, drift, Laplacian, mass term, force division and
// damping for one of the three fields. Depends on cfvs_pkg and cfvs_fmul.
module cfvs_lane #(
  parameter int W = 32,
  parameter int F = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfvs_pkg::cfvs_ctl_t ctl_i,
  input  logic signed [W-1:0] ph_i,
  input  logic signed [W-1:0] sp_i,
  input  logic signed [W-1:0] ac_i,
  input  logic signed [W-1:0] dt_i,
  input  logic signed [W-1:0] invdx_i,
  input  logic signed [W-1:0] mass_i,
  input  logic signed [W-1:0] dprev_i,
  input  logic signed [W-1:0] dmp_i,
  input  logic signed [W-1:0] oth0_i,
  input  logic signed [W-1:0] oth1_i,
  input  logic signed [W-1:0] mp_i,
  input  logic signed [W-1:0] den_i,
  output logic signed [W-1:0] ctr_o,
  output logic signed [W-1:0] oph_o,
  output logic signed [W-1:0] ov_o,
  output logic signed [W-1:0] acc_o,
  output logic                div_done_o
);
  import cfvs_pkg::*;

  localparam int DV_W  = W + F;
  localparam int CNT_W = $clog2(DV_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DV_W);
  localparam logic [DV_W-1:0]  QLIM_NEG  = DV_W'(1) << (W - 1);
  localparam logic [DV_W-1:0]  QLIM_POS  = (DV_W'(1) << (W - 1)) - DV_W'(1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    sadd = W'(sat_add(MAX_W'(a), MAX_W'(b), W));
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    ssub = W'(sat_sub(MAX_W'(a), MAX_W'(b), W));
  endfunction

  logic signed [W-1:0] ph_r, sp_r, ac_r, kv_r, dp_r, left_r, ctr_r, kvp_r;
  logic signed [W-1:0] acc_r, dpa_r, num_r, v_r, oph_r, ov_r;
  logic signed [W-1:0] a_op, b_op, res, d2, qv;
  logic                half;
  logic [CNT_W-1:0]    cnt_r;
  logic [W-1:0]        rem_r, rem_nxt, num_mag, den_u;
  logic [DV_W-1:0]     dvd_r, q_r;
  logic [W:0]          t, diff;
  logic                ge;

  cfvs_fmul #(.W(W), .F(F)) u_mul (
    .clk    (clk),
    .a_i    (a_op),
    .b_i    (b_op),
    .half_i (half),
    .res_o  (res)
  );

  assign d2 = ssub(sadd(dp_r, left_r), sadd(ctr_r, ctr_r));

  always_comb begin
    a_op = '0;
    b_op = '0;
    half = 1'b0;
    case (ctl_i.st)
      ST_KICK:   begin a_op = ac_r;   b_op = dt_i;    half = 1'b1; end
      ST_DRIFT:  begin a_op = kv_r;   b_op = dt_i;    end
      ST_LAP:    begin a_op = d2;     b_op = invdx_i; end
      ST_MASS:   begin a_op = mass_i; b_op = ctr_r;   end
      ST_DPROD:  begin a_op = oth0_i; b_op = oth1_i;  end
      ST_NUM:    begin a_op = mp_i;   b_op = dpa_r;   end
      ST_KICK2:  begin a_op = acc_r;  b_op = dt_i;    half = 1'b1; end
      ST_DAMPF:  begin a_op = ctr_r;  b_op = dprev_i; end
      ST_DAMPV:  begin a_op = v_r;    b_op = dprev_i; end
      ST_DAMPF2: begin a_op = dp_r;   b_op = dmp_i;   end
      ST_DAMPV2: begin a_op = kv_r;   b_op = dmp_i;   end
      default: ;
    endcase
  end

  assign num_mag = num_r[W-1] ? W'(-num_r) : W'(num_r);
  assign den_u   = den_i;
  assign t       = {rem_r, dvd_r[DV_W-1]};
  assign diff    = t - {1'b0, den_u};
  assign ge      = t >= {1'b0, den_u};
  assign rem_nxt = ge ? diff[W-1:0] : t[W-1:0];

  always_comb begin
    if (den_i <= 0) qv = '0;
    else if (num_r[W-1]) qv = (q_r > QLIM_NEG) ? VMIN : W'(DV_W'(0) - q_r);
    else qv = (q_r > QLIM_POS) ? VMAX : W'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl_i.st == ST_DIV && !ctl_i.ph) begin
      cnt_r <= DIV_STEPS;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.st == ST_DIV && !ctl_i.ph) begin
      rem_r <= '0;
      dvd_r <= {num_mag, {F{1'b0}}};
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
      q_r   <= {q_r[DV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      ph_r <= ph_i;
      sp_r <= sp_i;
      ac_r <= ac_i;
    end
    if (ctl_i.ph) begin
      case (ctl_i.st)
        ST_KICK:   kv_r <= ctl_i.bound ? sp_r : sadd(sp_r, res);
        ST_DRIFT: begin
          dp_r  <= ctl_i.bound ? ph_r : sadd(ph_r, res);
          acc_r <= '0;
          v_r   <= kvp_r;
        end
        ST_LAP:    acc_r <= res;
        ST_MASS:   acc_r <= ssub(acc_r, res);
        ST_DPROD:  dpa_r <= res;
        ST_NUM:    num_r <= res;
        ST_DIV:    if (cnt_r == '0) acc_r <= sadd(acc_r, qv);
        ST_KICK2:  v_r   <= sadd(kvp_r, res);
        ST_DAMPF:  oph_r <= res;
        ST_DAMPV:  ov_r  <= res;
        ST_DAMPF2: oph_r <= res;
        ST_DAMPV2: ov_r  <= res;
        default: ;
      endcase
    end
    if (ctl_i.shift) begin
      left_r <= ctr_r;
      ctr_r  <= dp_r;
      kvp_r  <= kv_r;
    end
  end

  assign ctr_o      = ctr_r;
  assign oph_o      = oph_r;
  assign ov_o       = ov_r;
  assign acc_o      = acc_r;
  assign div_done_o = (cnt_r == '0);

endmodule

// ===== src/cfvs_merge.sv =====
// Merging stage: combines the three lanes' centre fields into the shared
// force terms -mu*P and (1+kappa*P^2)^2. Depends on cfvs_pkg and cfvs_fmul.
module cfvs_merge #(
  parameter int W = 32,
  parameter int F = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic signed [W-1:0] c0_i,
  input  logic signed [W-1:0] c1_i,
  input  logic signed [W-1:0] c2_i,
  input  logic signed [W-1:0] kappa_i,
  input  logic signed [W-1:0] mu_i,
  output logic signed [W-1:0] mp_o,
  output logic signed [W-1:0] den_o,
  output logic                done_o
);
  import cfvs_pkg::*;

  typedef enum logic [5:0] {
    MS_Q    = 6'b000001,
    MS_PP   = 6'b000010,
    MS_P2   = 6'b000100,
    MS_BASE = 6'b001000,
    MS_DEN  = 6'b010000,
    MS_MP   = 6'b100000
  } merge_step_t;

  localparam logic signed [W-1:0] ONE =
    (F < W - 1) ? (W'(1) << F) : ((W'(1) << (W - 1)) - W'(1));

  logic                busy_r, ph_r;
  merge_step_t         step_r, step_nxt;
  logic signed [W-1:0] q_r, pp_r, p2_r, base_r, den_r, mp_r;
  logic signed [W-1:0] a_op, b_op, res, negmu;

  cfvs_fmul #(.W(W), .F(F)) u_mul (
    .clk    (clk),
    .a_i    (a_op),
    .b_i    (b_op),
    .half_i (1'b0),
    .res_o  (res)
  );

  assign negmu = W'(sat_sub('0, MAX_W'(mu_i), W));

  always_comb begin
    a_op     = '0;
    b_op     = '0;
    step_nxt = MS_Q;
    case (step_r)
      MS_Q:    begin a_op = c0_i;    b_op = c1_i;   step_nxt = MS_PP;   end
      MS_PP:   begin a_op = q_r;     b_op = c2_i;   step_nxt = MS_P2;   end
      MS_P2:   begin a_op = pp_r;    b_op = pp_r;   step_nxt = MS_BASE; end
      MS_BASE: begin a_op = kappa_i; b_op = p2_r;   step_nxt = MS_DEN;  end
      MS_DEN:  begin a_op = base_r;  b_op = base_r; step_nxt = MS_MP;   end
      MS_MP:   begin a_op = negmu;   b_op = pp_r;   step_nxt = MS_Q;    end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      step_r <= MS_Q;
    end else if (start_i) begin
      busy_r <= 1'b1;
      ph_r   <= 1'b0;
      step_r <= MS_Q;
    end else if (busy_r) begin
      ph_r <= !ph_r;
      if (ph_r) begin
        step_r <= step_nxt;
        if (step_r == MS_MP) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && ph_r) begin
      case (step_r)
        MS_Q:    q_r    <= res;
        MS_PP:   pp_r   <= res;
        MS_P2:   p2_r   <= res;
        MS_BASE: base_r <= W'(sat_add(MAX_W'(ONE), MAX_W'(res), W));
        MS_DEN:  den_r  <= res;
        MS_MP:   mp_r   <= res;
        default: ;
      endcase
    end
  end

  assign mp_o   = mp_r;
  assign den_o  = den_r;
  assign done_o = !busy_r;

endmodule

// ===== src/coupled_field_verlet_step.sv =====
// Top level of the coupled three-field Verlet stencil step: config registers,
// sequencer, three field lanes, force merge and output register.
// Depends on cfvs_pkg, cfvs_if, cfvs_lane, cfvs_merge.
//
//  channel   dir  handshake      payload
//  in_if     in   valid/ready    three fields, speeds, old accels, damping
//  out_if    out  valid/ready    new fields, speeds, accels, sweep_end
//  cfg_if    in   valid/ready    index, data (always ready)
//
// Points past the second of a sweep pass through the bit-serial force divider in
// each lane. One item is in work at a time; in_if.ready is high only between
// items. Reset is synchronous; config returns to defaults.
// A held result on out_if stalls the sequencer only when the next result is due.
module coupled_field_verlet_step #(
  parameter int VALUE_WIDTH   = cfvs_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = cfvs_pkg::FRACTION_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  cfvs_in_if.sink     in_if,
  cfvs_out_if.source  out_if,
  cfvs_cfg_if.sink    cfg_if
);
  import cfvs_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam int F = FRACTION_BITS;

  cfvs_state_t         state_r, state_nxt;
  logic                ph_r, ph_nxt;
  logic [PIDX_W-1:0]   pidx_r, npts;
  logic                bound_r, last_r, oldv_r, oldi_r, last_now;
  logic [F:0]          dmp_r, dprev_r;
  logic signed [W-1:0] mu_r;
  logic [W-2:0]        kappa_r, mass_r, invdx_r;
  logic [F:0]          dt_r;
  logic [PIDX_W-1:0]   grid_r;
  logic                accept, out_free, out_valid_r, mg_done, mg_start;
  logic                dd0, dd1, dd2;
  cfvs_ctl_t           ctl;
  logic signed [W-1:0] dt_s, kappa_s, mass_s, invdx_s, dprev_s, dmp_s;
  logic signed [W-1:0] ctr0, ctr1, ctr2, oph0, oph1, oph2, ov0, ov1, ov2;
  logic signed [W-1:0] acc0, acc1, acc2, mp, den;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= RST_MU[W-1:0];
      kappa_r <= RST_KAPPA[W-2:0];
      mass_r  <= RST_MASS[W-2:0];
      invdx_r <= RST_INVDX[W-2:0];
      dt_r    <= RST_DT[F:0];
      grid_r  <= RST_GRID;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_MU:    mu_r    <= cfg_if.data;
        CFG_KAPPA: kappa_r <= cfg_if.data[W-2:0];
        CFG_MASS:  mass_r  <= cfg_if.data[W-2:0];
        CFG_INVDX: invdx_r <= cfg_if.data[W-2:0];
        CFG_DT:    dt_r    <= cfg_if.data[F:0];
        CFG_GRID:  grid_r  <= cfg_if.data[PIDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign dt_s    = W'(dt_r);
  assign kappa_s = W'(kappa_r);
  assign mass_s  = W'(mass_r);
  assign invdx_s = W'(invdx_r);
  assign dprev_s = W'(dprev_r);
  assign dmp_s   = W'(dmp_r);

  assign npts     = (grid_r < MIN_POINTS) ? MIN_POINTS : grid_r;
  assign last_now = ({1'b0, pidx_r} + (PIDX_W+1)'(1)) >= {1'b0, npts};
  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign mg_start = accept && (pidx_r > PIDX_W'(1));
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    case (state_r)
      ST_IDLE:   if (accept) begin state_nxt = ST_KICK; ph_nxt = 1'b0; end
      ST_KICK:   begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_DRIFT; end
      ST_DRIFT: begin
        ph_nxt = !ph_r;
        if (ph_r) state_nxt = !oldv_r ? ST_FINISH : (oldi_r ? ST_LAP : ST_DAMPF);
      end
      ST_LAP:    begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_MASS; end
      ST_MASS:   begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_DPROD; end
      ST_DPROD:  begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_FWAIT; end
      ST_FWAIT:  if (mg_done) state_nxt = ST_NUM;
      ST_NUM:    begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_DIV; end
      ST_DIV: begin
        if (!ph_r) ph_nxt = 1'b1;
        else if (dd0) begin ph_nxt = 1'b0; state_nxt = ST_KICK2; end
      end
      ST_KICK2:  begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_DAMPF; end
      ST_DAMPF:  begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_DAMPV; end
      ST_DAMPV:  begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_EMIT1; end
      ST_EMIT1:  if (out_free) state_nxt = last_r ? ST_DAMPF2 : ST_FINISH;
      ST_DAMPF2: begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_DAMPV2; end
      ST_DAMPV2: begin ph_nxt = !ph_r; if (ph_r) state_nxt = ST_EMIT2; end
      ST_EMIT2:  if (out_free) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   begin state_nxt = ST_IDLE; ph_nxt = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= 1'b0;
      pidx_r  <= '0;
      bound_r <= 1'b0;
      last_r  <= 1'b0;
      oldv_r  <= 1'b0;
      oldi_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      if (accept) begin
        bound_r <= (pidx_r == '0) || last_now;
        last_r  <= last_now;
        oldv_r  <= (pidx_r != '0);
        oldi_r  <= (pidx_r > PIDX_W'(1));
      end
      if (state_r == ST_FINISH) pidx_r <= last_r ? '0 : pidx_r + PIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) dmp_r <= in_if.damping;
    if (state_r == ST_FINISH) dprev_r <= dmp_r;
  end

  assign ctl.st    = state_r;
  assign ctl.ph    = ph_r;
  assign ctl.bound = bound_r;
  assign ctl.load  = accept;
  assign ctl.shift = (state_r == ST_FINISH);

  cfvs_lane #(.W(W), .F(F)) u_lane0 (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl),
    .ph_i(in_if.field_one), .sp_i(in_if.speed_one), .ac_i(in_if.accel_one),
    .dt_i(dt_s), .invdx_i(invdx_s), .mass_i(mass_s), .dprev_i(dprev_s), .dmp_i(dmp_s),
    .oth0_i(ctr1), .oth1_i(ctr2), .mp_i(mp), .den_i(den),
    .ctr_o(ctr0), .oph_o(oph0), .ov_o(ov0), .acc_o(acc0), .div_done_o(dd0)
  );

  cfvs_lane #(.W(W), .F(F)) u_lane1 (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl),
    .ph_i(in_if.field_two), .sp_i(in_if.speed_two), .ac_i(in_if.accel_two),
    .dt_i(dt_s), .invdx_i(invdx_s), .mass_i(mass_s), .dprev_i(dprev_s), .dmp_i(dmp_s),
    .oth0_i(ctr0), .oth1_i(ctr2), .mp_i(mp), .den_i(den),
    .ctr_o(ctr1), .oph_o(oph1), .ov_o(ov1), .acc_o(acc1), .div_done_o(dd1)
  );

  cfvs_lane #(.W(W), .F(F)) u_lane2 (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl),
    .ph_i(in_if.field_three), .sp_i(in_if.speed_three), .ac_i(in_if.accel_three),
    .dt_i(dt_s), .invdx_i(invdx_s), .mass_i(mass_s), .dprev_i(dprev_s), .dmp_i(dmp_s),
    .oth0_i(ctr0), .oth1_i(ctr1), .mp_i(mp), .den_i(den),
    .ctr_o(ctr2), .oph_o(oph2), .ov_o(ov2), .acc_o(acc2), .div_done_o(dd2)
  );

  cfvs_merge #(.W(W), .F(F)) u_merge (
    .clk(clk), .rst_n(rst_n), .start_i(mg_start),
    .c0_i(ctr0), .c1_i(ctr1), .c2_i(ctr2), .kappa_i(kappa_s), .mu_i(mu_r),
    .mp_o(mp), .den_o(den), .done_o(mg_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT1 || state_r == ST_EMIT2) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT1 || state_r == ST_EMIT2) && out_free) begin
      out_if.new_field_one   <= oph0;
      out_if.new_field_two   <= oph1;
      out_if.new_field_three <= oph2;
      out_if.new_speed_one   <= ov0;
      out_if.new_speed_two   <= ov1;
      out_if.new_speed_three <= ov2;
      out_if.new_accel_one   <= (state_r == ST_EMIT2) ? '0 : acc0;
      out_if.new_accel_two   <= (state_r == ST_EMIT2) ? '0 : acc1;
      out_if.new_accel_three <= (state_r == ST_EMIT2) ? '0 : acc2;
      out_if.sweep_end       <= (state_r == ST_EMIT2);
    end
  end

  assign out_if.valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({dd0, dd1, dd2}) == 0 || $countones({dd0, dd1, dd2}) == 3)
    else $error("lane dividers out of step");

  a_emit2_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT2 |-> last_r && oldv_r)
    else $error("sweep end result without last point");

  a_force_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NUM |-> mg_done)
    else $error("force terms used before merge finished");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && last_r |=> pidx_r == '0)
    else $error("point index not cleared after last point");
`endif

endmodule

// ===== test/tb_coupled_field_verlet_step.sv =====
// Self-checking testbench for coupled_field_verlet_step: drives grid points and
// register writes and checks every result against an in-bench stencil predictor.
// Depends on cfvs_pkg, the cfvs_if interfaces and the RTL top level.
`timescale 1ns / 100ps

module tb_coupled_field_verlet_step;
  import cfvs_pkg::*;

  localparam int W = 32;
  localparam int F = 22;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1900;

  typedef logic [9:0][31:0] slot_vec_t;

  logic clk;
  logic rst_n;

  cfvs_in_if #(.W(W), .F(F)) in_ch ();
  cfvs_out_if #(.W(W)) out_ch ();
  cfvs_cfg_if #(.W(W)) cfg_ch ();

  coupled_field_verlet_step #(.VALUE_WIDTH(W), .FRACTION_BITS(F)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch), .cfg_if(cfg_ch)
  );

  // predictor copy of registers and stencil state
  longint mu_q, kappa_q, mass_q, invdx_q, dt_q;
  int unsigned grid_q;
  longint drift_win[6];
  longint speed_prev[3];
  longint damp_prev;
  int unsigned point_pos;

  slot_vec_t pending_results[$];
  int fail_count;
  int mismatch_count;
  longint cycle_count;
  bit steady;
  int items_sent;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint clampw(input longint x);
    return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    return clampw(a + b);
  endfunction

  function automatic longint sat_diff(input longint a, input longint b);
    return clampw(a - b);
  endfunction

  function automatic longint qmul(input longint a, input longint b, input int sh);
    logic [63:0] ua, ub;
    logic [127:0] p;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = ({64'd0, ua} * {64'd0, ub}) + (128'd1 << (sh - 1));
    p = p >> sh;
    if (neg) return p > 128'(VMAX + 1) ? VMIN : -longint'(p[63:0]);
    return p > 128'(VMAX) ? VMAX : longint'(p[63:0]);
  endfunction

  function automatic longint qdiv(input longint num, input longint den);
    logic [63:0] n, q;
    if (den <= 0) return 0;
    n = num < 0 ? -num : num;
    q = (n << F) / 64'(den);
    if (num < 0) return q > 64'(VMAX + 1) ? VMIN : -longint'(q);
    return q > 64'(VMAX) ? VMAX : longint'(q);
  endfunction

  function automatic longint coupling_force(input longint p0, input longint p1,
                                            input longint p2, input int lane);
    longint prod, dprod, psq, base, den, num;
    prod = qmul(qmul(p0, p1, F), p2, F);
    case (lane)
      0: dprod = qmul(p1, p2, F);
      1: dprod = qmul(p0, p2, F);
      default: dprod = qmul(p0, p1, F);
    endcase
    psq = qmul(prod, prod, F);
    base = sat_sum(longint'(1) << F, qmul(kappa_q, psq, F));
    den = qmul(base, base, F);
    num = qmul(qmul(sat_diff(0, mu_q), prod, F), dprod, F);
    return qdiv(num, den);
  endfunction

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_MU:    mu_q = longint'(signed'(data));
      CFG_KAPPA: kappa_q = longint'(data[30:0]);
      CFG_MASS:  mass_q = longint'(data[30:0]);
      CFG_INVDX: invdx_q = longint'(data[30:0]);
      CFG_DT:    dt_q = longint'(data[22:0]);
      CFG_GRID:  grid_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic advance_stencil(input slot_vec_t pt);
    int unsigned npts, i;
    logic last, bound;
    longint ph[3], kv[3], dp[3], oph[3], ov[3], oac[3];
    longint dmp, v, na, d2, lap;
    slot_vec_t res;
    npts = grid_q < 3 ? 3 : grid_q;
    i = point_pos;
    last = (i + 1 >= npts);
    bound = (i == 0) || last;
    dmp = longint'(pt[9][22:0]);
    for (int a = 0; a < 3; a++) begin
      ph[a] = longint'(signed'(pt[a]));
      if (bound) begin
        kv[a] = longint'(signed'(pt[3+a]));
        dp[a] = ph[a];
      end else begin
        kv[a] = sat_sum(longint'(signed'(pt[3+a])), qmul(longint'(signed'(pt[6+a])), dt_q, F + 1));
        dp[a] = sat_sum(ph[a], qmul(kv[a], dt_q, F));
      end
    end
    if (i >= 1) begin
      for (int a = 0; a < 3; a++) begin
        v = speed_prev[a];
        na = 0;
        if (i != 1) begin
          d2 = sat_diff(sat_sum(dp[a], drift_win[a]), sat_sum(drift_win[3+a], drift_win[3+a]));
          lap = qmul(d2, invdx_q, F);
          na = sat_sum(sat_diff(lap, qmul(mass_q, drift_win[3+a], F)),
                       coupling_force(drift_win[3], drift_win[4], drift_win[5], a));
          v = sat_sum(v, qmul(na, dt_q, F + 1));
        end
        res[a] = 32'(qmul(drift_win[3+a], damp_prev, F));
        res[3+a] = 32'(qmul(v, damp_prev, F));
        res[6+a] = 32'(na);
      end
      res[9] = 32'd0;
      pending_results.push_back(res);
    end
    if (last) begin
      for (int a = 0; a < 3; a++) begin
        res[a] = 32'(qmul(dp[a], dmp, F));
        res[3+a] = 32'(qmul(kv[a], dmp, F));
        res[6+a] = 32'd0;
      end
      res[9] = 32'd1;
      pending_results.push_back(res);
      point_pos = 0;
    end else begin
      point_pos = (i + 1) & 16'hFFFF;
    end
    for (int a = 0; a < 3; a++) begin
      drift_win[a] = drift_win[3+a];
      drift_win[3+a] = dp[a];
      speed_prev[a] = kv[a];
    end
    damp_prev = dmp;
  endtask

  always @(negedge clk) out_ch.ready <= steady || ($urandom_range(0, 99) >= 22);

  always @(posedge clk) begin
    slot_vec_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {31'd0, out_ch.sweep_end, out_ch.new_accel_three, out_ch.new_accel_two,
             out_ch.new_accel_one, out_ch.new_speed_three, out_ch.new_speed_two,
             out_ch.new_speed_one, out_ch.new_field_three, out_ch.new_field_two,
             out_ch.new_field_one};
      if (pending_results.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item at cycle %0d", cycle_count);
      end else begin
        want = pending_results.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (got[k] !== want[k]) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch slot %0d: expected %h actual %h (cycle %0d)",
                       k, want[k], got[k], cycle_count);
          end
        end
      end
    end
  end

  task automatic send_point(input slot_vec_t pt);
    while (!steady && $urandom_range(0, 99) < 22) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.field_one = pt[0];
    in_ch.field_two = pt[1];
    in_ch.field_three = pt[2];
    in_ch.speed_one = pt[3];
    in_ch.speed_two = pt[4];
    in_ch.speed_three = pt[5];
    in_ch.accel_one = pt[6];
    in_ch.accel_two = pt[7];
    in_ch.accel_three = pt[8];
    in_ch.damping = pt[9][22:0];
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    advance_stencil(pt);
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    apply_register(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: case ($urandom_range(0, 4))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 32'hffffffff;
           3: return 32'd1;
           default: return 32'd0;
         endcase
      default: return 32'($urandom_range(0, 2 << F)) - (32'd1 << F);
    endcase
  endfunction

  function automatic slot_vec_t rand_point();
    slot_vec_t pt;
    for (int k = 0; k < 9; k++) pt[k] = rand_value();
    pt[9] = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 8388607))
                                      : 32'($urandom_range(3800000, 4194304));
    return pt;
  endfunction

  function automatic slot_vec_t flat_point(input logic [31:0] val, input logic [31:0] damp);
    slot_vec_t pt;
    for (int k = 0; k < 9; k++) pt[k] = val;
    pt[9] = damp;
    return pt;
  endfunction

  task automatic test_default_sweep_shrunk;
    repeat (4) send_point(rand_point());
    drain();
    write_register(CFG_GRID, 32'd3);
    send_point(rand_point());
    drain();
  endtask

  task automatic test_short_sweep;
    write_register(CFG_GRID, 32'd1);
    repeat (3) send_point(rand_point());
    drain();
    write_register(CFG_GRID, 32'd0);
    repeat (3) send_point(rand_point());
    drain();
  endtask

  task automatic test_field_extremes;
    write_register(CFG_GRID, 32'd5);
    send_point(flat_point(32'h7fffffff, 32'd4194304));
    send_point(flat_point(32'h80000000, 32'd8388607));
    send_point(flat_point(32'h7fffffff, 32'd0));
    send_point(flat_point(32'h00000000, 32'd4194304));
    send_point(flat_point(32'hffffffff, 32'd8388607));
    drain();
  endtask

  task automatic test_register_extremes;
    write_register(CFG_MU, 32'h7fffffff);
    write_register(CFG_KAPPA, 32'h7fffffff);
    write_register(CFG_MASS, 32'h7fffffff);
    write_register(CFG_INVDX, 32'h7fffffff);
    write_register(CFG_DT, 32'h007fffff);
    write_register(CFG_GRID, 32'd3);
    repeat (3) send_point(rand_point());
    drain();
    write_register(CFG_MU, 32'h80000000);
    write_register(CFG_KAPPA, 32'd0);
    write_register(CFG_MASS, 32'd0);
    write_register(CFG_INVDX, 32'd0);
    write_register(CFG_DT, 32'd0);
    repeat (3) send_point(rand_point());
    drain();
    write_register(CFG_GRID, 32'hffff);
    repeat (3) send_point(rand_point());
    drain();
    write_register(CFG_GRID, 32'd4);
    send_point(rand_point());
    drain();
  endtask

  task automatic test_random_sweeps;
    int phase;
    int target;
    phase = 0;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      write_register(CFG_MU, $urandom_range(0, 3) == 0 ? $urandom
                                                       : 32'($urandom_range(0, 1 << 25)) - (32'd1 << 24));
      write_register(CFG_KAPPA, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 26));
      write_register(CFG_MASS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 23));
      write_register(CFG_INVDX, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 30));
      write_register(CFG_DT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8388607)
                                                      : $urandom_range(0, 1 << 20));
      write_register(CFG_GRID, $urandom_range(0, 5) == 0 ? $urandom_range(0, 40)
                                                        : $urandom_range(3, 12));
      steady = (phase == 3);
      repeat ($urandom_range(60, 150)) send_point(rand_point());
      steady = 1'b0;
      drain();
      phase++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    steady = 1'b0;
    fail_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    items_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.field_one = '0;
    in_ch.field_two = '0;
    in_ch.field_three = '0;
    in_ch.speed_one = '0;
    in_ch.speed_two = '0;
    in_ch.speed_three = '0;
    in_ch.accel_one = '0;
    in_ch.accel_two = '0;
    in_ch.accel_three = '0;
    in_ch.damping = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int k = 0; k < 6; k++) drift_win[k] = 0;
    for (int k = 0; k < 3; k++) speed_prev[k] = 0;
    damp_prev = 0;
    point_pos = 0;
    apply_register(CFG_MU, 32'(RST_MU));
    apply_register(CFG_KAPPA, 32'(RST_KAPPA));
    apply_register(CFG_MASS, 32'(RST_MASS));
    apply_register(CFG_INVDX, 32'(RST_INVDX));
    apply_register(CFG_DT, 32'(RST_DT));
    apply_register(CFG_GRID, 32'(RST_GRID));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_sweep_shrunk();
    test_short_sweep();
    test_field_extremes();
    test_register_extremes();
    test_random_sweeps();

    drain();
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cfvs_pkg.sv
src/cfvs_if.sv
src/cfvs_fmul.sv
src/cfvs_lane.sv
src/cfvs_merge.sv
src/coupled_field_verlet_step.sv
test/tb_coupled_field_verlet_step.sv
